// ===== hdl/silf_pkg.sv =====
// Shared constants, register codes and types for the spectral inverse Laplacian filter.
package silf_pkg;

    localparam int DIM_MAX_DEF      = 512;
    localparam int SAMPLE_WIDTH_DEF = 24;

    localparam int SIZE_W    = 10;
    localparam int WORD_W    = 32;
    localparam int FRAC_W    = 16;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_X_SIZE,
        REG_Y_SIZE,
        REG_Z_SIZE,
        REG_KX_STEP,
        REG_KY_STEP,
        REG_KZ_STEP,
        REG_ALPHA,
        REG_GAIN_NORM
    } t_cfg_reg;

    localparam logic [SIZE_W-1:0] X_SIZE_RST    = SIZE_W'(64);
    localparam logic [SIZE_W-1:0] Y_SIZE_RST    = SIZE_W'(64);
    localparam logic [SIZE_W-1:0] Z_SIZE_RST    = SIZE_W'(64);
    localparam logic [WORD_W-1:0] STEP_RST      = '0;
    localparam logic [WORD_W-1:0] ALPHA_RST     = WORD_W'(65536);
    localparam logic [WORD_W-1:0] GAIN_NORM_RST = WORD_W'(65536);

    // One gain bit, most significant first, from the divider to the scaler.
    typedef struct packed {
        logic vld;
        logic qb;
        logic fin;
    } t_qbit;

endpackage

// ===== hdl/silf_pos.sv =====
// Bin position counters, size clamping and frequency folding.
module silf_pos #(
    parameter int DIM_MAX = silf_pkg::DIM_MAX_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_advance,
    input  logic [silf_pkg::SIZE_W-1:0]        i_x_size,
    input  logic [silf_pkg::SIZE_W-1:0]        i_y_size,
    input  logic [silf_pkg::SIZE_W-1:0]        i_z_size,
    output logic [$clog2(DIM_MAX)-1:0]         o_fold_i,
    output logic [$clog2(DIM_MAX)-1:0]         o_fold_j,
    output logic [$clog2(DIM_MAX)-1:0]         o_fold_k,
    output logic                               o_last
);
    import silf_pkg::*;

    localparam int IDX_W = $clog2(DIM_MAX);
    localparam int DIM_W = $clog2(DIM_MAX + 1);
    localparam int CMP_W = ((DIM_W > SIZE_W) ? DIM_W : SIZE_W) + 1;

    function automatic logic [DIM_W-1:0] eff_size(input logic [SIZE_W-1:0] v);
        logic [CMP_W-1:0] wide;
        wide = CMP_W'(v);
        if (v == '0) begin
            return DIM_W'(1);
        end else if (wide > CMP_W'(DIM_MAX)) begin
            return DIM_W'(DIM_MAX);
        end else begin
            return DIM_W'(v);
        end
    endfunction

    function automatic logic [IDX_W-1:0] fold(input logic [IDX_W-1:0] idx,
                                              input logic [DIM_W-1:0] size);
        logic [CMP_W-1:0] wi;
        logic [CMP_W-1:0] ws;
        wi = CMP_W'(idx);
        ws = CMP_W'(size);
        if (wi <= (ws >> 1)) begin
            return idx;
        end else if (wi < ws) begin
            return IDX_W'(ws - wi);
        end else begin
            return IDX_W'(wi - ws);
        end
    endfunction

    logic [IDX_W-1:0] r_x_idx;
    logic [IDX_W-1:0] r_y_idx;
    logic [IDX_W-1:0] r_z_idx;
    logic [DIM_W-1:0] eff_x;
    logic [DIM_W-1:0] eff_y;
    logic [DIM_W-1:0] eff_z;
    logic             x_last;
    logic             y_last;
    logic             z_last;

    always_comb begin
        eff_x  = eff_size(i_x_size);
        eff_y  = eff_size(i_y_size);
        eff_z  = eff_size(i_z_size);
        x_last = CMP_W'(r_x_idx) >= CMP_W'(eff_x >> 1);
        y_last = CMP_W'(r_y_idx) >= (CMP_W'(eff_y) - CMP_W'(1));
        z_last = CMP_W'(r_z_idx) >= (CMP_W'(eff_z) - CMP_W'(1));
    end

    assign o_fold_i = r_x_idx;
    assign o_fold_j = fold(r_y_idx, eff_y);
    assign o_fold_k = fold(r_z_idx, eff_z);
    assign o_last   = x_last & y_last & z_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_idx <= '0;
            r_y_idx <= '0;
            r_z_idx <= '0;
        end else if (i_advance) begin
            if (!x_last) begin
                r_x_idx <= r_x_idx + IDX_W'(1);
            end else begin
                r_x_idx <= '0;
                if (!y_last) begin
                    r_y_idx <= r_y_idx + IDX_W'(1);
                end else begin
                    r_y_idx <= '0;
                    r_z_idx <= z_last ? '0 : (r_z_idx + IDX_W'(1));
                end
            end
        end
    end

endmodule

// ===== hdl/silf_den.sv =====
// Bit-serial multiply-accumulate of squared frequencies into the gain denominator.
module silf_den #(
    parameter int DIM_MAX = silf_pkg::DIM_MAX_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_start,
    input  logic [$clog2(DIM_MAX)-1:0]                    i_fold_i,
    input  logic [$clog2(DIM_MAX)-1:0]                    i_fold_j,
    input  logic [$clog2(DIM_MAX)-1:0]                    i_fold_k,
    input  logic [silf_pkg::WORD_W-1:0]                   i_kx,
    input  logic [silf_pkg::WORD_W-1:0]                   i_ky,
    input  logic [silf_pkg::WORD_W-1:0]                   i_kz,
    input  logic [silf_pkg::WORD_W-1:0]                   i_alpha,
    output logic                                          o_done,
    output logic [2*$clog2(DIM_MAX)+silf_pkg::WORD_W+1:0] o_den
);
    import silf_pkg::*;

    localparam int IDX_W = $clog2(DIM_MAX);
    localparam int SQ_W  = 2 * IDX_W;
    localparam int HI_W  = WORD_W + 2;
    localparam int DEN_W = SQ_W + HI_W;
    localparam int CNT_W = $clog2(SQ_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [SQ_W-1:0]  r_sq_i;
    logic [SQ_W-1:0]  r_sq_j;
    logic [SQ_W-1:0]  r_sq_k;
    logic [HI_W-1:0]  r_hi;
    logic [SQ_W-1:0]  r_lo;
    logic [DEN_W-1:0] r_den;
    logic [HI_W:0]    n_sum;

    always_comb begin
        n_sum = (HI_W+1)'(r_hi)
              + (HI_W+1)'(r_sq_i[0] ? i_kx : '0)
              + (HI_W+1)'(r_sq_j[0] ? i_ky : '0)
              + (HI_W+1)'(r_sq_k[0] ? i_kz : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_cnt == CNT_W'(SQ_W));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CNT_W'(SQ_W)) begin
                    r_busy <= 1'b0;
                end else begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sq_i <= SQ_W'(i_fold_i) * SQ_W'(i_fold_i);
            r_sq_j <= SQ_W'(i_fold_j) * SQ_W'(i_fold_j);
            r_sq_k <= SQ_W'(i_fold_k) * SQ_W'(i_fold_k);
            r_hi   <= '0;
            r_lo   <= '0;
        end else if (r_busy) begin
            if (r_cnt == CNT_W'(SQ_W)) begin
                r_den <= {r_hi, r_lo} + DEN_W'(i_alpha);
            end else begin
                r_hi   <= n_sum[HI_W:1];
                r_lo   <= {n_sum[0], r_lo[SQ_W-1:1]};
                r_sq_i <= r_sq_i >> 1;
                r_sq_j <= r_sq_j >> 1;
                r_sq_k <= r_sq_k >> 1;
            end
        end
    end

    assign o_done = r_done;
    assign o_den  = r_den;

endmodule

// ===== hdl/silf_div.sv =====
// Restoring divider that emits the saturated Q16.16 gain one bit per cycle, MSB first.
module silf_div #(
    parameter int DIM_MAX = silf_pkg::DIM_MAX_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_start,
    input  logic [2*$clog2(DIM_MAX)+silf_pkg::WORD_W+1:0] i_den,
    input  logic [silf_pkg::WORD_W-1:0]                   i_norm,
    output silf_pkg::t_qbit                               o_q
);
    import silf_pkg::*;

    localparam int DEN_W = 2 * $clog2(DIM_MAX) + WORD_W + 2;
    localparam int CNT_W = $clog2(WORD_W);

    logic             r_busy;
    logic             r_sat;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [WORD_W-1:0] r_num;
    t_qbit            r_q;
    logic [DEN_W:0]   trial;
    logic             fits;
    logic             n_sat;

    always_comb begin
        trial = {r_rem, r_num[WORD_W-1]};
        fits  = trial >= {1'b0, r_den};
        // quotient overflows 32 bits when den <= norm / 2^16, zero included
        n_sat = i_den <= DEN_W'(i_norm[WORD_W-1:FRAC_W]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_q    <= '0;
        end else begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_q    <= '0;
            end else if (r_busy) begin
                r_q.vld <= 1'b1;
                r_q.qb  <= fits | r_sat;
                r_q.fin <= (r_cnt == CNT_W'(WORD_W - 1));
                r_cnt   <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(WORD_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end else begin
                r_q <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            r_sat <= n_sat;
            r_rem <= DEN_W'(i_norm[WORD_W-1:FRAC_W]);
            r_num <= {i_norm[FRAC_W-1:0], {(WORD_W-FRAC_W){1'b0}}};
        end else if (r_busy) begin
            r_rem <= fits ? DEN_W'(trial - {1'b0, r_den}) : DEN_W'(trial);
            r_num <= r_num << 1;
        end
    end

    assign o_q = r_q;

endmodule

// ===== hdl/silf_scale.sv =====
// Serial gain multiply of both sample parts, floor shift and saturation.
module silf_scale #(
    parameter int SAMPLE_WIDTH = silf_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_load,
    input  logic signed [SAMPLE_WIDTH-1:0] i_re,
    input  logic signed [SAMPLE_WIDTH-1:0] i_im,
    input  silf_pkg::t_qbit                i_q,
    output logic                           o_done,
    output logic signed [SAMPLE_WIDTH-1:0] o_re,
    output logic signed [SAMPLE_WIDTH-1:0] o_im
);
    import silf_pkg::*;

    localparam int ACC_W = SAMPLE_WIDTH + WORD_W;
    localparam int Q_W   = ACC_W - FRAC_W;

    function automatic logic signed [SAMPLE_WIDTH-1:0] sat(input logic signed [ACC_W-1:0] a);
        logic [Q_W-1:0] q;
        q = a[ACC_W-1:FRAC_W];
        if (q[Q_W-1:SAMPLE_WIDTH-1] == '0 || q[Q_W-1:SAMPLE_WIDTH-1] == '1) begin
            return q[SAMPLE_WIDTH-1:0];
        end else if (q[Q_W-1]) begin
            return {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
        end else begin
            return {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
        end
    endfunction

    logic                           r_done;
    logic signed [SAMPLE_WIDTH-1:0] r_x_re;
    logic signed [SAMPLE_WIDTH-1:0] r_x_im;
    logic signed [ACC_W-1:0]        r_acc_re;
    logic signed [ACC_W-1:0]        r_acc_im;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_q.vld & i_q.fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_x_re   <= i_re;
            r_x_im   <= i_im;
            r_acc_re <= '0;
            r_acc_im <= '0;
        end else if (i_q.vld) begin
            r_acc_re <= (r_acc_re <<< 1) + (i_q.qb ? ACC_W'(r_x_re) : '0);
            r_acc_im <= (r_acc_im <<< 1) + (i_q.qb ? ACC_W'(r_x_im) : '0);
        end
    end

    assign o_done = r_done;
    assign o_re   = sat(r_acc_re);
    assign o_im   = sat(r_acc_im);

endmodule

// ===== hdl/spectral_inverse_laplacian_filter.sv =====
// Top level of the spectral inverse Laplacian filter: registers, sequencing and output stage.
// Each item passes the bit-serial denominator accumulate over the squared index bits and the
// 32-step gain divide; the input stalls until its result has entered the output register.
// The output register frees the input side while a result waits on a stalled consumer.
// Reset is synchronous, active low: registers return to defaults and the bin position to zero.
module spectral_inverse_laplacian_filter #(
    parameter int DIM_MAX      = silf_pkg::DIM_MAX_DEF,
    parameter int SAMPLE_WIDTH = silf_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [silf_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [silf_pkg::WORD_W-1:0]       i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]    i_bin_re,
    input  logic signed [SAMPLE_WIDTH-1:0]    i_bin_im,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [SAMPLE_WIDTH-1:0]    o_out_re,
    output logic signed [SAMPLE_WIDTH-1:0]    o_out_im,
    output logic                              o_last_bin
);
    import silf_pkg::*;

    localparam int IDX_W = $clog2(DIM_MAX);
    localparam int DEN_W = 2 * IDX_W + WORD_W + 2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DEN,
        S_DIV,
        S_OUT
    } t_state;

    t_state                   r_state;
    logic                     r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_out_re;
    logic signed [SAMPLE_WIDTH-1:0] r_out_im;
    logic                     r_out_last;
    logic                     r_last;

    logic [SIZE_W-1:0]        r_x_size;
    logic [SIZE_W-1:0]        r_y_size;
    logic [SIZE_W-1:0]        r_z_size;
    logic [WORD_W-1:0]        r_kx;
    logic [WORD_W-1:0]        r_ky;
    logic [WORD_W-1:0]        r_kz;
    logic [WORD_W-1:0]        r_alpha;
    logic [WORD_W-1:0]        r_norm;

    logic                     accept;
    logic [IDX_W-1:0]         fold_i;
    logic [IDX_W-1:0]         fold_j;
    logic [IDX_W-1:0]         fold_k;
    logic                     pos_last;
    logic                     den_done;
    logic [DEN_W-1:0]         den;
    t_qbit                    qbit;
    logic                     scale_done;
    logic signed [SAMPLE_WIDTH-1:0] scaled_re;
    logic signed [SAMPLE_WIDTH-1:0] scaled_im;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid & ~o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_size <= X_SIZE_RST;
            r_y_size <= Y_SIZE_RST;
            r_z_size <= Z_SIZE_RST;
            r_kx     <= STEP_RST;
            r_ky     <= STEP_RST;
            r_kz     <= STEP_RST;
            r_alpha  <= ALPHA_RST;
            r_norm   <= GAIN_NORM_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_X_SIZE:    r_x_size <= i_cfg_data[SIZE_W-1:0];
                REG_Y_SIZE:    r_y_size <= i_cfg_data[SIZE_W-1:0];
                REG_Z_SIZE:    r_z_size <= i_cfg_data[SIZE_W-1:0];
                REG_KX_STEP:   r_kx     <= i_cfg_data;
                REG_KY_STEP:   r_ky     <= i_cfg_data;
                REG_KZ_STEP:   r_kz     <= i_cfg_data;
                REG_ALPHA:     r_alpha  <= i_cfg_data;
                REG_GAIN_NORM: r_norm   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    silf_pos #(
        .DIM_MAX (DIM_MAX)
    ) u_pos (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (accept),
        .i_x_size  (r_x_size),
        .i_y_size  (r_y_size),
        .i_z_size  (r_z_size),
        .o_fold_i  (fold_i),
        .o_fold_j  (fold_j),
        .o_fold_k  (fold_k),
        .o_last    (pos_last)
    );

    silf_den #(
        .DIM_MAX (DIM_MAX)
    ) u_den (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (accept),
        .i_fold_i (fold_i),
        .i_fold_j (fold_j),
        .i_fold_k (fold_k),
        .i_kx     (r_kx),
        .i_ky     (r_ky),
        .i_kz     (r_kz),
        .i_alpha  (r_alpha),
        .o_done   (den_done),
        .o_den    (den)
    );

    silf_div #(
        .DIM_MAX (DIM_MAX)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (den_done),
        .i_den   (den),
        .i_norm  (r_norm),
        .o_q     (qbit)
    );

    silf_scale #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept),
        .i_re    (i_bin_re),
        .i_im    (i_bin_im),
        .i_q     (qbit),
        .o_done  (scale_done),
        .o_re    (scaled_re),
        .o_im    (scaled_im)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_last      <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_last  <= pos_last;
                        r_state <= S_DEN;
                    end
                end
                S_DEN: begin
                    if (den_done) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (scale_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // hold until the output register is free
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_re    <= scaled_re;
                        r_out_im    <= scaled_im;
                        r_out_last  <= r_last;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_re    = r_out_re;
    assign o_out_im    = r_out_im;
    assign o_last_bin  = r_out_last;

endmodule

// ===== verif/tb_spectral_inverse_laplacian_filter.sv =====
// Testbench for the spectral inverse Laplacian filter: directed table and random volumes.
module tb_spectral_inverse_laplacian_filter;
    import silf_pkg::*;

    localparam int SW       = SAMPLE_WIDTH_DEF;
    localparam int DIM      = DIM_MAX_DEF;
    localparam int LATENCY  = 60;
    localparam int LIMIT    = 3000;

    typedef struct {
        logic signed [SW-1:0] re;
        logic signed [SW-1:0] im;
        logic                 last;
    } t_bin_res;

    typedef struct {
        bit                   is_cfg;
        t_cfg_reg             cfg_sel;
        logic [WORD_W-1:0]    cfg_val;
        logic signed [SW-1:0] re;
        logic signed [SW-1:0] im;
        bit                   typed;
        t_bin_res             want;
    } t_dir_row;

    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [WORD_W-1:0]    i_cfg_data  = '0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    logic signed [SW-1:0] i_bin_re    = '0;
    logic signed [SW-1:0] i_bin_im    = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic signed [SW-1:0] o_out_re;
    logic signed [SW-1:0] o_out_im;
    logic                 o_last_bin;

    logic [SIZE_W-1:0] sz_x = X_SIZE_RST, sz_y = Y_SIZE_RST, sz_z = Z_SIZE_RST;
    logic [WORD_W-1:0] kx = STEP_RST, ky = STEP_RST, kz = STEP_RST;
    logic [WORD_W-1:0] alpha = ALPHA_RST, norm = GAIN_NORM_RST;
    logic [8:0]        pos_x = '0, pos_y = '0, pos_z = '0;

    t_bin_res filtered_q[$];
    t_dir_row dir_q[$];
    bit       cur_typed = 1'b0;
    t_bin_res cur_want;
    int       idle_pct  = 0;
    int       stall_pct = 0;
    int       err_cnt   = 0;
    int       quiet     = 0;

    spectral_inverse_laplacian_filter DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_bin_re    (i_bin_re),
        .i_bin_im    (i_bin_im),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_re    (o_out_re),
        .o_out_im    (o_out_im),
        .o_last_bin  (o_last_bin)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned eff_size(logic [SIZE_W-1:0] v);
        if (v < 1) return 1;
        if (v > DIM) return DIM;
        return v;
    endfunction

    function automatic longint unsigned fold_idx(int unsigned idx, int unsigned size);
        if (idx <= size / 2) return idx;
        if (idx < size) return size - idx;
        return idx - size;
    endfunction

    function automatic logic signed [SW-1:0] sat_scale(logic signed [SW-1:0] s,
                                                        longint unsigned g);
        longint p;
        longint q;
        longint hi;
        hi = (longint'(1) << (SW - 1)) - 1;
        p  = longint'(s) * longint'(g);
        q  = p >>> FRAC_W;
        if (q > hi) q = hi;
        if (q < -hi - 1) q = -hi - 1;
        return q[SW-1:0];
    endfunction

    function automatic t_bin_res filter_bin(logic signed [SW-1:0] re, logic signed [SW-1:0] im);
        int unsigned     nxb, ny, nz;
        longint unsigned fi, fj, fk, den, g;
        bit              xl, yl, zl;
        t_bin_res        r;
        nxb = eff_size(sz_x) / 2 + 1;
        ny  = eff_size(sz_y);
        nz  = eff_size(sz_z);
        fi  = pos_x;
        fj  = fold_idx(pos_y, ny);
        fk  = fold_idx(pos_z, nz);
        den = 64'(alpha) + fi * fi * 64'(kx) + fj * fj * 64'(ky) + fk * fk * 64'(kz);
        xl  = pos_x >= nxb - 1;
        yl  = pos_y >= ny - 1;
        zl  = pos_z >= nz - 1;
        if (den == 0) begin
            g = 64'hFFFF_FFFF;
        end else begin
            g = (64'(norm) << FRAC_W) / den;
            if (g > 64'hFFFF_FFFF) g = 64'hFFFF_FFFF;
        end
        r.re   = sat_scale(re, g);
        r.im   = sat_scale(im, g);
        r.last = xl && yl && zl;
        if (!xl) begin
            pos_x = pos_x + 1'b1;
        end else begin
            pos_x = '0;
            if (!yl) begin
                pos_y = pos_y + 1'b1;
            end else begin
                pos_y = '0;
                pos_z = zl ? 9'd0 : pos_z + 1'b1;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $time, what);
        err_cnt++;
    endtask

    always @(posedge i_clk) begin : in_mon
        t_bin_res r;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            r = filter_bin(i_bin_re, i_bin_im);
            if (cur_typed) r = cur_want;
            filtered_q.push_back(r);
        end
    end

    always @(posedge i_clk) begin : out_mon
        t_bin_res e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (filtered_q.size() == 0) begin
                report_mismatch("result with nothing pending");
            end else begin
                e = filtered_q.pop_front();
                if (o_out_re !== e.re)
                    report_mismatch($sformatf("out_re got %0d want %0d", o_out_re, e.re));
                if (o_out_im !== e.im)
                    report_mismatch($sformatf("out_im got %0d want %0d", o_out_im, e.im));
                if (o_last_bin !== e.last)
                    report_mismatch($sformatf("last_bin got %b want %b", o_last_bin, e.last));
            end
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_in_valid && !o_in_stall)
            || (o_out_valid && !i_out_stall)) begin
            quiet <= 0;
        end else if (quiet >= LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    function automatic void add_cfg_row(t_cfg_reg r, logic [WORD_W-1:0] v);
        t_dir_row row;
        row.is_cfg  = 1'b1;
        row.cfg_sel = r;
        row.cfg_val = v;
        row.re      = '0;
        row.im      = '0;
        row.typed   = 1'b0;
        dir_q.push_back(row);
    endfunction

    function automatic void add_bin_row(int re, int im, bit typed, int w_re, int w_im,
                                        bit w_last);
        t_dir_row row;
        row.is_cfg    = 1'b0;
        row.cfg_sel   = REG_X_SIZE;
        row.cfg_val   = '0;
        row.re        = SW'(re);
        row.im        = SW'(im);
        row.typed     = typed;
        row.want.re   = SW'(w_re);
        row.want.im   = SW'(w_im);
        row.want.last = w_last;
        dir_q.push_back(row);
    endfunction

    task automatic set_reg(t_cfg_reg r, logic [WORD_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= r;
        i_cfg_data  <= v;
        @(posedge i_clk);
        case (r)
            REG_X_SIZE:    sz_x  = v[SIZE_W-1:0];
            REG_Y_SIZE:    sz_y  = v[SIZE_W-1:0];
            REG_Z_SIZE:    sz_z  = v[SIZE_W-1:0];
            REG_KX_STEP:   kx    = v;
            REG_KY_STEP:   ky    = v;
            REG_KZ_STEP:   kz    = v;
            REG_ALPHA:     alpha = v;
            REG_GAIN_NORM: norm  = v;
            default: begin
            end
        endcase
    endtask

    // hold off input until every pending bin has come out
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (filtered_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic send_bin(logic signed [SW-1:0] re, logic signed [SW-1:0] im, bit typed,
                            t_bin_res want);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_bin_re   <= re;
        i_bin_im   <= im;
        cur_typed  <= typed;
        cur_want   <= want;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    function automatic logic [WORD_W-1:0] pick_size(bit is_x);
        logic [WORD_W-1:0] v;
        int                r;
        r = $urandom_range(0, 99);
        if (r < 70)      v = is_x ? $urandom_range(2, 10) : $urandom_range(1, 6);
        else if (r < 80) v = 1;
        else if (r < 88) v = DIM;
        else if (r < 94) v = $urandom_range(0, 1023);
        else             v = $urandom_range(0, 1) ? 0 : 1023;
        if ($urandom_range(0, 9) == 0) v[WORD_W-1:SIZE_W] = (WORD_W-SIZE_W)'($urandom);
        return v;
    endfunction

    function automatic logic [WORD_W-1:0] pick_step();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) return 0;
        if (r < 30) return 32'hFFFF_FFFF;
        if (r < 60) return $urandom_range(0, 32'h3_FFFF);
        return $urandom;
    endfunction

    function automatic logic [WORD_W-1:0] pick_alpha();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)  return 0;
        if (r < 15) return 1;
        if (r < 25) return 32'hFFFF_FFFF;
        if (r < 60) return $urandom_range(32'h1000, 32'h10_0000);
        return $urandom;
    endfunction

    function automatic logic [WORD_W-1:0] pick_norm();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 0;
        if (r < 20) return 32'hFFFF_FFFF;
        if (r < 60) return $urandom_range(32'h4000, 32'h4_0000);
        return $urandom;
    endfunction

    function automatic logic signed [SW-1:0] pick_sample();
        case ($urandom_range(0, 19))
            0:       return {1'b0, {(SW-1){1'b1}}};
            1:       return {1'b1, {(SW-1){1'b0}}};
            2:       return '0;
            3:       return '1;
            default: return SW'($urandom);
        endcase
    endfunction

    task automatic new_volume_setup();
        drain();
        set_reg(REG_X_SIZE, pick_size(1'b1));
        set_reg(REG_Y_SIZE, pick_size(1'b0));
        set_reg(REG_Z_SIZE, pick_size(1'b0));
        set_reg(REG_KX_STEP, pick_step());
        set_reg(REG_KY_STEP, pick_step());
        set_reg(REG_KZ_STEP, pick_step());
        set_reg(REG_ALPHA, pick_alpha());
        set_reg(REG_GAIN_NORM, pick_norm());
        i_cfg_we <= 1'b0;
    endtask

    initial begin : main_seq
        t_bin_res none;
        bit       cfg_open;
        int       n;
        int       cnt;
        none.re   = '0;
        none.im   = '0;
        none.last = 1'b0;
        cfg_open  = 1'b0;

        add_bin_row(8388607, -8388608, 1, 8388607, -8388608, 0);
        add_bin_row(0, 0, 1, 0, 0, 0);
        add_bin_row(-1, 1, 1, -1, 1, 0);
        add_bin_row(5592405, -5592406, 1, 5592405, -5592406, 0);
        add_cfg_row(REG_GAIN_NORM, 32'h0002_0000);
        add_bin_row(8388607, -8388608, 1, 8388607, -8388608, 0);
        add_bin_row(-1, 3, 1, -2, 6, 0);
        add_cfg_row(REG_GAIN_NORM, 32'h0);
        add_bin_row(-5, 7, 1, 0, 0, 0);
        add_cfg_row(REG_GAIN_NORM, 32'h1);
        add_bin_row(-1, 1, 1, -1, 0, 0);
        add_bin_row(-65536, 65537, 1, -1, 1, 0);
        add_cfg_row(REG_ALPHA, 32'h0);
        add_cfg_row(REG_GAIN_NORM, 32'h0001_0000);
        add_cfg_row(REG_X_SIZE, 32'h2);
        add_cfg_row(REG_Y_SIZE, 32'h1);
        add_cfg_row(REG_Z_SIZE, 32'h1);
        add_bin_row(1, -1, 1, 65535, -65536, 1);
        add_bin_row(2, -8388608, 1, 131071, -8388608, 0);
        add_bin_row(8388607, 0, 1, 8388607, 0, 1);
        add_cfg_row(REG_X_SIZE, 32'hFFFF_FC06);
        add_cfg_row(REG_Y_SIZE, 32'h0000_03FF);
        add_cfg_row(REG_Z_SIZE, 32'h0);
        add_cfg_row(REG_KX_STEP, 32'h0001_0000);
        add_cfg_row(REG_KY_STEP, 32'h0000_3000);
        add_cfg_row(REG_KZ_STEP, 32'hFFFF_FFFF);
        add_cfg_row(REG_ALPHA, 32'h0000_8000);
        add_cfg_row(REG_GAIN_NORM, 32'hFFFF_FFFF);
        add_bin_row(100, -100, 0, 0, 0, 0);
        add_bin_row(8388607, -8388608, 0, 0, 0, 0);
        add_bin_row(-1, 1, 0, 0, 0, 0);
        add_bin_row(4096, -4096, 0, 0, 0, 0);
        add_bin_row(1234567, -7654321, 0, 0, 0, 0);
        add_bin_row(8323072, -1, 0, 0, 0, 0);

        repeat (2) @(posedge i_clk);
        i_rst_n   <= 1'b1;
        idle_pct  = 15;
        stall_pct = 74;

        foreach (dir_q[k]) begin
            if (dir_q[k].is_cfg) begin
                if (!cfg_open) drain();
                set_reg(dir_q[k].cfg_sel, dir_q[k].cfg_val);
                cfg_open = 1'b1;
            end else begin
                if (cfg_open) i_cfg_we <= 1'b0;
                cfg_open = 1'b0;
                send_bin(dir_q[k].re, dir_q[k].im, dir_q[k].typed, dir_q[k].want);
            end
        end

        for (int m = 0; m < 3; m++) begin
            case (m)
                0: begin idle_pct = 15; stall_pct = 74; end
                1: begin idle_pct = 74; stall_pct = 15; end
                default: begin idle_pct = 0; stall_pct = 0; end
            endcase
            n = 0;
            while (n < 455) begin
                new_volume_setup();
                cnt = $urandom_range(8, 64);
                repeat (cnt) send_bin(pick_sample(), pick_sample(), 1'b0, none);
                n += cnt;
            end
        end

        i_in_valid <= 1'b0;
        while (filtered_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
        if (err_cnt == 0 && filtered_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/silf_pkg.sv
hdl/silf_pos.sv
hdl/silf_den.sv
hdl/silf_div.sv
hdl/silf_scale.sv
hdl/spectral_inverse_laplacian_filter.sv
verif/tb_spectral_inverse_laplacian_filter.sv
